[design/p1305_pkg.sv]
// ----------------------------------------------------------------------------
// Poly1305 package
// Shared types and constants for the Poly1305 authenticator.
// ----------------------------------------------------------------------------
package p1305_pkg;

  localparam logic [127:0] ClampMask = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
  localparam int unsigned  LimbW     = 26;
  localparam int unsigned  NumLimbs  = 5;

  // Block register indexes.
  typedef enum logic [1:0] {
    REG_R_LOW  = 2'd0,
    REG_R_HIGH = 2'd1,
    REG_S_LOW  = 2'd2,
    REG_S_HIGH = 2'd3
  } reg_idx_e;

  // One classified block queued from the front end to the engine.
  typedef struct packed {
    logic [129:0] blk;     // padded message block with the high 1 bit
    logic         absorb;  // block carries message bytes
    logic         last;    // emit the tag after this block
  } job_t;

endpackage

[design/p1305_front.sv]
// ----------------------------------------------------------------------------
// Poly1305 front end
// Masks and pads each input block and passes it on through a two-entry queue.
// ----------------------------------------------------------------------------
module p1305_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [63:0]       block_low_i,
  input  logic [63:0]       block_high_i,
  input  logic [4:0]        byte_count_i,
  input  logic              last_block_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output p1305_pkg::job_t   job_o
);
  import p1305_pkg::*;

  logic [4:0]   n;
  logic [127:0] raw, mask;
  logic [129:0] padded;
  job_t         job_in;
  job_t         q_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  always_comb begin
    n    = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
    raw  = {block_high_i, block_low_i};
    mask = (n == 5'd16) ? '1 : ((128'd1 << {n, 3'b000}) - 128'd1);
    padded = {2'b00, raw & mask} | (130'd1 << {n, 3'b000});
    job_in.blk    = padded;
    job_in.absorb = (n != 5'd0);
    job_in.last   = last_block_i;
  end

  // Items with no bytes and no last flag change nothing; they are dropped.
  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && (job_in.absorb || job_in.last);
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/p1305_engine.sv]
// ----------------------------------------------------------------------------
// Poly1305 engine
// Multiplies the accumulator by r modulo 2^130-5 with one shared limb
// multiplier and forms the tag on the last block.
// ----------------------------------------------------------------------------
module p1305_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [127:0]      r_i,
  input  logic [127:0]      s_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  p1305_pkg::job_t   job_i,
  output logic              tag_valid_o,
  input  logic              tag_ready_i,
  output logic [127:0]      tag_o
);
  import p1305_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RED  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_TAG  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [129:0]  acc_q;
  logic [130:0]  h_q;       // acc + block, below 2^131
  logic [127:0]  rc;
  logic [25:0]   hl [NumLimbs];
  logic [25:0]   rl [NumLimbs];
  logic [28:0]   hl5;
  logic [2:0]    i_q, j_q;
  logic [3:0]    ij_sum;
  logic          wrap;
  logic [57:0]   d_q [NumLimbs];
  logic [57:0]   prod;
  logic          last_q;
  logic [127:0]  tag_q;
  logic          tag_v_q;
  logic [2:0]    k;
  logic [263:0]  full;
  logic [133:0]  red1;
  logic [133:0]  red1_q;
  logic [130:0]  red2;
  logic [130:0]  g;

  assign rc = r_i & ClampMask;

  always_comb begin
    for (int m = 0; m < NumLimbs; m++) begin
      hl[m] = h_q[m*LimbW +: LimbW];
      rl[m] = rc[m*LimbW +: LimbW];
    end
  end

  // One 29 by 26 product a cycle: h limb i (times 5 when it wraps) by r limb j.
  always_comb begin
    ij_sum = {1'b0, i_q} + {1'b0, j_q};
    wrap   = (ij_sum > 4'd4);
    hl5  = ({3'b000, hl[i_q]} + {h_q[130] && (i_q == 3'd4), 26'd0})
         * (wrap ? 29'd5 : 29'd1);
    prod = {29'd0, hl5} * {32'd0, rl[j_q]};
    k    = wrap ? 3'(ij_sum - 4'd5) : ij_sum[2:0];
  end

  // Limb sums to full value and a first fold at bit 130.
  always_comb begin
    full = '0;
    for (int m = 0; m < NumLimbs; m++) begin
      full = full + ({206'd0, d_q[m]} << (m * LimbW));
    end
    red1 = {4'd0, full[129:0]} + ({70'd0, full[193:130]} * 134'd5);
  end

  // Second fold from the registered value, then the trial subtraction of p.
  always_comb begin
    red2 = {1'b0, red1_q[129:0]} + ({127'd0, red1_q[133:130]} * 131'd5);
    g    = red2 + 131'd5;
  end

  assign job_ready_o = (state_q == ST_IDLE) && !tag_v_q;
  assign tag_valid_o = tag_v_q;
  assign tag_o       = tag_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (job_valid_i && job_ready_o)
                 state_d = job_i.absorb ? ST_MUL : ST_TAG;
      ST_MUL:  if (i_q == 3'd4 && j_q == 3'd4) state_d = ST_RED;
      ST_RED:  state_d = ST_FIN;
      ST_FIN:  state_d = last_q ? ST_TAG : ST_IDLE;
      ST_TAG:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      tag_v_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tag_v_q && tag_ready_i) tag_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (job_valid_i && job_ready_o) begin
          last_q <= job_i.last;
          i_q    <= '0;
          j_q    <= '0;
        end
        ST_MUL: begin
          if (j_q == 3'd4) begin
            j_q <= '0;
            i_q <= i_q + 3'd1;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end
        ST_FIN:  acc_q <= g[130] ? g[129:0] : red2[129:0];
        ST_TAG: begin
          tag_v_q <= 1'b1;
          acc_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (job_valid_i && job_ready_o) begin
        h_q <= {1'b0, acc_q} + {1'b0, job_i.blk};
        for (int m = 0; m < NumLimbs; m++) d_q[m] <= '0;
      end
      ST_MUL:  d_q[k] <= d_q[k] + prod;
      ST_RED:  red1_q <= red1;
      ST_TAG:  tag_q <= acc_q[127:0] + s_i;
      default: ;
    endcase
  end

endmodule

[design/poly1305_mac.sv]
// ----------------------------------------------------------------------------
// Poly1305 MAC
// Top level: key registers, block front end and the multiply engine.
// ----------------------------------------------------------------------------
// An absorbed block goes through a load step, a multiply phase in which a
// single 29 by 26 bit limb multiplier forms the products of the 5 by 5 limb
// schoolbook product one by one, a reduction step and a final compare; a
// last block adds a tag step, and a zero-length last item goes from the
// load step straight to it. The front end pads each block and holds up to two,
// so transfers go on while the engine is busy or a tag waits, until full.
// The user must write key registers only while idle; the block has no check.
module poly1305_mac (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,   // block_low, block_high, byte_count, pad
  input  logic          s_axis_tlast,   // last_block
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // tag_low, tag_high
);
  import p1305_pkg::*;

  logic [63:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_lo_q <= '0;
      r_hi_q <= '0;
      s_lo_q <= '0;
      s_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_R_LOW:  r_lo_q <= cfg_data_i;
        REG_R_HIGH: r_hi_q <= cfg_data_i;
        REG_S_LOW:  s_lo_q <= cfg_data_i;
        REG_S_HIGH: s_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  p1305_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .block_low_i  (s_axis_tdata[63:0]),
    .block_high_i (s_axis_tdata[127:64]),
    .byte_count_i (s_axis_tdata[132:128]),
    .last_block_i (s_axis_tlast),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  p1305_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .r_i         ({r_hi_q, r_lo_q}),
    .s_i         ({s_hi_q, s_lo_q}),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .tag_valid_o (m_axis_tvalid),
    .tag_ready_i (m_axis_tready),
    .tag_o       (m_axis_tdata)
  );

endmodule

[tb/sv/poly1305_tag_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Poly1305 tag checker
// Watches the key write port and both stream channels, computes the expected
// tag of every message and compares it with each tag transfer.
// ----------------------------------------------------------------------------
module poly1305_tag_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  output int           fail_count_o,
  output int           tag_count_o,
  output int           pending_o
);
  import p1305_pkg::*;

  localparam logic [130:0] Prime = (131'd1 << 130) - 131'd5;

  logic [127:0] key_r, key_s;
  logic [129:0] acc;
  logic [127:0] tag_queue[$];

  // Modular product by shift-and-add, both operands below 2^131.
  function automatic logic [129:0] mul_mod(logic [130:0] a, logic [127:0] b);
    logic [131:0] res;
    logic [131:0] base;
    int i;
    res = 0;
    base = a % Prime;
    for (i = 0; i < 128; i++) begin
      if (b[i]) begin
        res = res + base;
        if (res >= Prime) res = res - Prime;
      end
      base = base << 1;
      if (base >= Prime) base = base - Prime;
    end
    return res[129:0];
  endfunction

  task automatic absorb_block(logic [127:0] data, logic [4:0] count_raw, logic last);
    logic [130:0] blk;
    int n;
    n = (count_raw > 16) ? 16 : count_raw;
    if (n > 0) begin
      blk = 0;
      for (int b = 0; b < n; b++) blk[8*b +: 8] = data[8*b +: 8];
      blk[8*n] = 1'b1;
      acc = mul_mod({1'b0, acc} + blk, key_r & ClampMask);
    end
    if (last) begin
      tag_queue.push_back(acc[127:0] + key_s);
      acc = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_r <= 0;
      key_s <= 0;
      acc = 0;
      fail_count_o <= 0;
      tag_count_o <= 0;
      pending_o <= 0;
      tag_queue.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_R_LOW:  key_r[63:0]   <= cfg_data_i;
          REG_R_HIGH: key_r[127:64] <= cfg_data_i;
          REG_S_LOW:  key_s[63:0]   <= cfg_data_i;
          REG_S_HIGH: key_s[127:64] <= cfg_data_i;
          default: ;
        endcase
      end
      // Check the outgoing tag before a new message can add to the queue.
      if (m_axis_tvalid && m_axis_tready) begin
        tag_count_o <= tag_count_o + 1;
        if (tag_queue.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected tag %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (m_axis_tdata !== tag_queue[0]) begin
            if (fail_count_o < 10)
              $display("Tag mismatch: expected %h actual %h", tag_queue[0], m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
          void'(tag_queue.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_block(s_axis_tdata[127:0], s_axis_tdata[132:128], s_axis_tlast);
      pending_o <= tag_queue.size();
    end
  end

endmodule

[tb/sv/poly1305_mac_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Poly1305 MAC testbench
// Drives key settings and messages of random and edge-case blocks into the
// authenticator, with random idling on both channels; a checker computes and
// compares every tag.
// ----------------------------------------------------------------------------
module poly1305_mac_test;
  import p1305_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  int fail_count, tag_count, pending;
  int block_count;
  // When set, neither side idles.
  logic steady = 1'b0;

  poly1305_mac uut (.*);

  poly1305_tag_checker checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .tag_count_o(tag_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The tag receiver stalls in about a quarter of the cycles.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 24);
  end

  // Writes one key register while the block is idle. The enable stays high
  // so that writes can follow back to back; load_keys drops it at the end.
  task automatic write_key(reg_idx_e idx, logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Sends one block transfer, with an optional random gap before it. The
  // valid stays high from one transfer to the next when there is no gap.
  task automatic send_block(logic [127:0] data, logic [4:0] count, logic last);
    while (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, count, data};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    block_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] key_word(int mode);
    case (mode)
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Lets the block drain so keys can be rewritten safely.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_keys(int mode);
    write_key(REG_R_LOW, key_word(mode));
    write_key(REG_R_HIGH, key_word(mode));
    write_key(REG_S_LOW, key_word(mode));
    write_key(REG_S_HIGH, key_word(mode));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [4:0] cnt;
    int msg_len;
    block_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: key extremes, field extremes, count above sixteen,
    // zero count with and without last, empty message.
    load_keys(1);
    send_block('1, 5'd16, 1'b0);
    send_block('0, 5'd16, 1'b0);
    send_block('1, 5'd1, 1'b0);
    send_block('1, 5'd7, 1'b0);
    send_block('1, 5'd8, 1'b0);
    send_block('1, 5'd9, 1'b0);
    send_block('1, 5'd15, 1'b0);
    send_block('1, 5'd31, 1'b0);
    send_block('1, 5'd17, 1'b0);
    send_block('1, 5'd0, 1'b0);
    send_block('1, 5'd16, 1'b1);
    send_block('1, 5'd0, 1'b1);
    send_block('0, 5'd0, 1'b1);
    drain();
    load_keys(0);
    send_block('1, 5'd16, 1'b0);
    send_block({rand64(), rand64()}, 5'd3, 1'b1);
    send_block('0, 5'd0, 1'b1);
    drain();

    // Random messages, with one phase that has no idling at all.
    for (int phase = 0; phase < 8; phase++) begin
      load_keys(phase == 3 ? 1 : 2);
      steady = (phase == 5);
      for (int m = 0; m < 20; m++) begin
        msg_len = $urandom_range(6);
        for (int b = 0; b < msg_len; b++) begin
          // Mostly full blocks; sometimes a short one or an ignored zero.
          cnt = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'd16;
          send_block({rand64(), rand64()}, cnt, 1'b0);
        end
        cnt = ($urandom_range(4) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        send_block({rand64(), rand64()}, cnt, 1'b1);
      end
      steady = 1'b0;
      drain();
    end

    $display("Sent %0d blocks; %0d tags checked over ten key settings.",
             block_count, tag_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
design/p1305_pkg.sv
design/p1305_front.sv
design/p1305_engine.sv
design/poly1305_mac.sv
tb/sv/poly1305_tag_checker.sv
tb/sv/poly1305_mac_test.sv
